>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion helpers
// clocked checks on i_clk, held off while i_rst_n is low
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/cbb_pkg.sv
// ---------------------------------------------------------------------------
// cbb_pkg
// shared types and constants of the circular byte buffer
// ---------------------------------------------------------------------------
`default_nettype none

package cbb_pkg;

    localparam int MAX_DEPTH   = 1024;
    localparam int MAX_REQUEST = 64;

    localparam int PTR_W  = $clog2(MAX_DEPTH);
    localparam int CNT_W  = PTR_W + 1;
    localparam int LEN_W  = 7;
    localparam int BYTE_W = 8;
    localparam int STAT_W = 3;

    localparam logic [CNT_W-1:0] CAP_MAX   = CNT_W'(MAX_DEPTH);
    localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_REQUEST);
    localparam logic [LEN_W-1:0] POS_SAT   = {LEN_W{1'b1}};
    localparam logic [PTR_W-1:0] ADDR_LAST = PTR_W'(MAX_DEPTH - 1);

    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NONE  = 2'd3
    } t_req_type;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_EMPTY     = 3'd1,
        STAT_UNDERFLOW = 3'd2,
        STAT_FULL      = 3'd3,
        STAT_OVERFLOW  = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SPACE,
        S_ADMIT,
        S_WRITE,
        S_CLEAR,
        S_RD_EVAL,
        S_RD_FETCH,
        S_RD_EMIT,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic [BYTE_W-1:0] rd_byte;
        t_status           status;
        logic [CNT_W-1:0]  xfer_count;
        logic [CNT_W-1:0]  fill_after;
        logic              last_result;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/core/circular_byte_buffer_core.sv
// ---------------------------------------------------------------------------
// circular_byte_buffer_core
// byte ring buffer with block read requests and admitted write runs
// ---------------------------------------------------------------------------
// One request is handled at a time; s_axis_tready is high only while the
// sequencer idles. A write byte item steps through space, admit, write,
// result and back to idle when it opens a run, and through write, result
// and idle inside a run. A refused or zero-length read steps through
// evaluate, result and idle. A read of n bytes evaluates once, then for each
// byte does a registered read of the 1024 x 8 byte store and loads the
// output register. A clear zeroes the 1024 store entries one per cycle
// before its result. A result waiting on m_axis_tready stalls the sequencer.
// The free space, length compares and pointer wrap go through one shared
// 11-bit subtractor stepped by the sequencer. The result register lets the
// next request be worked up to its result while the previous result is
// still waiting on m_axis_tready. The byte store has no reset, so an entry
// read before it is ever written is undefined; capacity changes take effect
// at once and do not clear the buffer.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module circular_byte_buffer_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // capacity register write
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [10:0] i_cfg_data,
    // request stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // req_length[6:0], allow_partial[7], wr_byte[15:8]
    input  wire logic [1:0]  s_axis_tuser,   // req_type[1:0]
    input  wire logic        s_axis_tlast,   // wr_last
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // rd_byte[7:0], xfer_count[18:8],
                                             // fill_after[29:19], zero[31:30]
    output logic [2:0]       m_axis_tuser,   // status[2:0]
    output logic             m_axis_tlast    // last_result
);

    localparam int PW = cbb_pkg::PTR_W;
    localparam int CW = cbb_pkg::CNT_W;
    localparam int LW = cbb_pkg::LEN_W;
    localparam int BW = cbb_pkg::BYTE_W;

    // sequencer and buffer state
    cbb_pkg::t_state   r_state, n_state;
    logic [CW-1:0]     r_cap;
    logic [PW-1:0]     r_rptr, n_rptr;
    logic [PW-1:0]     r_wptr, n_wptr;
    logic [CW-1:0]     r_fill, n_fill;

    // write run bookkeeping
    logic              r_in_run, n_in_run;
    logic [LW-1:0]     r_run_pos, n_run_pos;
    logic [LW-1:0]     r_run_adm, n_run_adm;
    cbb_pkg::t_status  r_run_stat, n_run_stat;

    // latched request
    cbb_pkg::t_req_type r_type, n_type;
    logic [LW-1:0]     r_len, n_len;
    logic              r_part, n_part;
    logic [BW-1:0]     r_byte, n_byte;
    logic              r_last, n_last;

    // working registers
    logic [CW-1:0]     r_space, n_space;
    logic [LW-1:0]     r_n, n_n;
    logic [LW-1:0]     r_k, n_k;
    logic [PW-1:0]     r_clr, n_clr;
    logic [BW-1:0]     r_rd_data;
    cbb_pkg::t_result  r_res, n_res;

    // output register
    logic              r_m_valid, n_m_valid;
    cbb_pkg::t_result  r_m_res, n_m_res;

    // byte store
    logic [BW-1:0]     r_mem [cbb_pkg::MAX_DEPTH];
    logic              mem_we;
    logic [PW-1:0]     mem_addr;
    logic [BW-1:0]     mem_wdata;

    // shared subtract/compare unit
    logic [CW-1:0]     alu_a, alu_b;
    logic [CW:0]       alu_diff;
    logic              alu_ge;

    // read decision
    logic [LW-1:0]     rd_cnt;
    cbb_pkg::t_status  rd_stat;

    logic              s_fire;
    logic              out_free;
    logic [LW-1:0]     in_len;

    assign s_fire   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_m_valid || m_axis_tready;
    assign in_len   = (s_axis_tdata[6:0] > cbb_pkg::LEN_MAX) ? cbb_pkg::LEN_MAX
                                                              : s_axis_tdata[6:0];

    // operand selection per step
    always_comb begin
        alu_a = '0;
        alu_b = '0;
        unique case (r_state)
            cbb_pkg::S_SPACE: begin
                alu_a = r_cap;
                alu_b = r_fill;
            end
            cbb_pkg::S_ADMIT: begin
                alu_a = r_space;
                alu_b = CW'(r_len);
            end
            cbb_pkg::S_WRITE: begin
                alu_a = CW'(r_wptr) + CW'(1);
                alu_b = r_cap;
            end
            cbb_pkg::S_RD_EVAL: begin
                alu_a = r_fill;
                alu_b = CW'(r_len);
            end
            cbb_pkg::S_RD_FETCH: begin
                alu_a = CW'(r_rptr) + CW'(1);
                alu_b = r_cap;
            end
            default: begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
    assign alu_ge   = !alu_diff[CW];

    // read length decision: whole, partial or refused
    always_comb begin
        rd_cnt  = '0;
        rd_stat = cbb_pkg::STAT_OK;
        priority if (r_len == '0) begin
            rd_cnt = '0;
        end else if (r_fill == '0) begin
            rd_stat = cbb_pkg::STAT_EMPTY;
        end else if (alu_ge) begin
            rd_cnt = r_len;
        end else if (r_part) begin
            rd_cnt = r_fill[LW-1:0];    // fill below len, so it fits
        end else begin
            rd_stat = cbb_pkg::STAT_UNDERFLOW;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cbb_pkg::S_IDLE: begin
                if (s_fire) begin
                    unique case (cbb_pkg::t_req_type'(s_axis_tuser))
                        cbb_pkg::REQ_READ:  n_state = cbb_pkg::S_RD_EVAL;
                        cbb_pkg::REQ_WRITE: n_state = r_in_run ? cbb_pkg::S_WRITE
                                                               : cbb_pkg::S_SPACE;
                        cbb_pkg::REQ_CLEAR: n_state = cbb_pkg::S_CLEAR;
                        cbb_pkg::REQ_NONE:  n_state = cbb_pkg::S_IDLE;
                        default:            n_state = cbb_pkg::S_IDLE;
                    endcase
                end
            end
            cbb_pkg::S_SPACE:    n_state = cbb_pkg::S_ADMIT;
            cbb_pkg::S_ADMIT:    n_state = cbb_pkg::S_WRITE;
            cbb_pkg::S_WRITE:    n_state = cbb_pkg::S_RESULT;
            cbb_pkg::S_CLEAR: begin
                n_state = (r_clr == cbb_pkg::ADDR_LAST) ? cbb_pkg::S_RESULT
                                                        : cbb_pkg::S_CLEAR;
            end
            cbb_pkg::S_RD_EVAL: begin
                n_state = (rd_cnt == '0) ? cbb_pkg::S_RESULT : cbb_pkg::S_RD_FETCH;
            end
            cbb_pkg::S_RD_FETCH: n_state = cbb_pkg::S_RD_EMIT;
            cbb_pkg::S_RD_EMIT: begin
                if (out_free) begin
                    n_state = (r_k == r_n) ? cbb_pkg::S_IDLE : cbb_pkg::S_RD_FETCH;
                end
            end
            cbb_pkg::S_RESULT: begin
                if (out_free) begin
                    n_state = cbb_pkg::S_IDLE;
                end
            end
            default: n_state = cbb_pkg::S_IDLE;
        endcase
    end

    // datapath updates
    always_comb begin
        n_rptr     = r_rptr;
        n_wptr     = r_wptr;
        n_fill     = r_fill;
        n_in_run   = r_in_run;
        n_run_pos  = r_run_pos;
        n_run_adm  = r_run_adm;
        n_run_stat = r_run_stat;
        n_type     = r_type;
        n_len      = r_len;
        n_part     = r_part;
        n_byte     = r_byte;
        n_last     = r_last;
        n_space    = r_space;
        n_n        = r_n;
        n_k        = r_k;
        n_clr      = r_clr;
        n_res      = r_res;
        n_m_res    = r_m_res;
        n_m_valid  = r_m_valid && !m_axis_tready;
        mem_we     = 1'b0;

        unique case (r_state)
            cbb_pkg::S_IDLE: begin
                n_clr = '0;
                if (s_fire) begin
                    n_type = cbb_pkg::t_req_type'(s_axis_tuser);
                    n_len  = in_len;
                    n_part = s_axis_tdata[7];
                    n_byte = s_axis_tdata[15:8];
                    n_last = s_axis_tlast;
                end
            end
            cbb_pkg::S_SPACE: begin
                // free slots, zero when fill has reached the capacity
                n_space = alu_ge ? alu_diff[CW-1:0] : '0;
            end
            cbb_pkg::S_ADMIT: begin
                n_run_adm  = '0;
                n_run_stat = cbb_pkg::STAT_OK;
                priority if (r_len == '0) begin
                    n_run_adm = '0;
                end else if (r_space == '0) begin
                    n_run_stat = cbb_pkg::STAT_FULL;
                end else if (alu_ge) begin
                    n_run_adm = r_len;
                end else if (r_part) begin
                    n_run_adm = r_space[LW-1:0];
                end else begin
                    n_run_stat = cbb_pkg::STAT_OVERFLOW;
                end
                n_in_run  = 1'b1;
                n_run_pos = '0;
            end
            cbb_pkg::S_WRITE: begin
                n_res.rd_byte     = '0;
                n_res.status      = r_run_stat;
                n_res.last_result = r_last;
                if (r_run_pos < r_run_adm) begin
                    mem_we           = 1'b1;
                    n_wptr           = alu_ge ? '0 : alu_a[PW-1:0];
                    n_fill           = r_fill + CW'(1);
                    n_res.xfer_count = CW'(r_run_pos) + CW'(1);
                end else begin
                    n_res.xfer_count = CW'(r_run_adm);
                end
                n_res.fill_after = n_fill;
                if (r_run_pos != cbb_pkg::POS_SAT) begin
                    n_run_pos = r_run_pos + LW'(1);
                end
                if (r_last) begin
                    n_in_run   = 1'b0;
                    n_run_pos  = '0;
                    n_run_adm  = '0;
                    n_run_stat = cbb_pkg::STAT_OK;
                end
            end
            cbb_pkg::S_CLEAR: begin
                // zero one store entry per cycle, then report the old fill
                mem_we     = 1'b1;
                n_clr      = r_clr + PW'(1);
                n_in_run   = 1'b0;
                n_run_pos  = '0;
                n_run_adm  = '0;
                n_run_stat = cbb_pkg::STAT_OK;
                if (r_clr == cbb_pkg::ADDR_LAST) begin
                    n_res.rd_byte     = '0;
                    n_res.status      = cbb_pkg::STAT_OK;
                    n_res.xfer_count  = r_fill;
                    n_res.fill_after  = '0;
                    n_res.last_result = 1'b1;
                    n_rptr            = '0;
                    n_wptr            = '0;
                    n_fill            = '0;
                end
            end
            cbb_pkg::S_RD_EVAL: begin
                // a read ends any open write run
                n_in_run          = 1'b0;
                n_run_pos         = '0;
                n_run_adm         = '0;
                n_run_stat        = cbb_pkg::STAT_OK;
                n_n               = rd_cnt;
                n_k               = '0;
                n_res.rd_byte     = '0;
                n_res.status      = rd_stat;
                n_res.xfer_count  = '0;
                n_res.fill_after  = r_fill;
                n_res.last_result = 1'b1;
            end
            cbb_pkg::S_RD_FETCH: begin
                n_rptr = alu_ge ? '0 : alu_a[PW-1:0];
                n_fill = r_fill - CW'(1);
                n_k    = r_k + LW'(1);
            end
            cbb_pkg::S_RD_EMIT: begin
                if (out_free) begin
                    n_m_valid           = 1'b1;
                    n_m_res.rd_byte     = r_rd_data;
                    n_m_res.status      = cbb_pkg::STAT_OK;
                    n_m_res.xfer_count  = CW'(r_k);
                    n_m_res.fill_after  = r_fill;
                    n_m_res.last_result = (r_k == r_n);
                end
            end
            cbb_pkg::S_RESULT: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_res   = r_res;
                end
            end
            default: begin
                n_m_valid = r_m_valid && !m_axis_tready;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= cbb_pkg::S_IDLE;
            r_cap      <= cbb_pkg::CAP_MAX;
            r_rptr     <= '0;
            r_wptr     <= '0;
            r_fill     <= '0;
            r_in_run   <= 1'b0;
            r_run_pos  <= '0;
            r_run_adm  <= '0;
            r_run_stat <= cbb_pkg::STAT_OK;
            r_m_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rptr     <= n_rptr;
            r_wptr     <= n_wptr;
            r_fill     <= n_fill;
            r_in_run   <= n_in_run;
            r_run_pos  <= n_run_pos;
            r_run_adm  <= n_run_adm;
            r_run_stat <= n_run_stat;
            r_m_valid  <= n_m_valid;
            // capacity saturates to 1..MAX_DEPTH on write
            if (i_cfg_valid && o_cfg_ready) begin
                priority if (i_cfg_data == '0) begin
                    r_cap <= CW'(1);
                end else if (i_cfg_data > cbb_pkg::CAP_MAX) begin
                    r_cap <= cbb_pkg::CAP_MAX;
                end else begin
                    r_cap <= i_cfg_data;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_type  <= n_type;
        r_len   <= n_len;
        r_part  <= n_part;
        r_byte  <= n_byte;
        r_last  <= n_last;
        r_space <= n_space;
        r_n     <= n_n;
        r_k     <= n_k;
        r_clr   <= n_clr;
        r_res   <= n_res;
        r_m_res <= n_m_res;
    end

    // store write port: data bytes, or zeros during a clear
    assign mem_addr  = (r_state == cbb_pkg::S_CLEAR) ? r_clr : r_wptr;
    assign mem_wdata = (r_state == cbb_pkg::S_CLEAR) ? '0 : r_byte;

    // byte store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        if (r_state == cbb_pkg::S_RD_FETCH) begin
            r_rd_data <= r_mem[r_rptr];
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == cbb_pkg::S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {2'b00, r_m_res.fill_after, r_m_res.xfer_count, r_m_res.rd_byte};
    assign m_axis_tuser  = r_m_res.status;
    assign m_axis_tlast  = r_m_res.last_result;

    // checks
    `AST_IMPLY(a_fill_bound, 1'b1, r_fill <= cbb_pkg::CAP_MAX, "fill above store depth")
    `AST_IMPLY(a_fetch_nonempty, r_state == cbb_pkg::S_RD_FETCH, r_fill != '0,
               "byte fetch from empty buffer")
    `AST_IMPLY(a_emit_count, r_state == cbb_pkg::S_RD_EMIT, (r_k != '0) && (r_k <= r_n),
               "read byte count out of range")
    `AST_NEXT(a_clear_empties,
              (r_state == cbb_pkg::S_CLEAR) && (r_clr == cbb_pkg::ADDR_LAST),
              r_fill == '0, "clear left bytes in buffer")

endmodule

`default_nettype wire
